[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock once reset has been released
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/hbd_pkg.sv]
package hbd_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LEN     = 1'd1;
  localparam int CFG_DATA_W = 32;

  // error codes reported with each result
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SIZE  = 2'd1;
  localparam logic [1:0] ERR_TERM  = 2'd2;
  localparam logic [1:0] ERR_AFTER = 2'd3;

  // characters of the framing
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_start;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_ext;
  } hbd_item_t;

endpackage

[sv/hbd_in_if.sv]
interface hbd_in_if import hbd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_start;

  modport source (output valid, output body_byte, output body_start, input ready);
  modport sink (input valid, input body_byte, input body_start, output ready);
endinterface

[sv/hbd_out_if.sv]
interface hbd_out_if import hbd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       body_done;
  logic [1:0] error_code;

  modport source (output valid, output data_byte, output data_valid, output body_done,
                  output error_code, input ready);
  modport sink (input valid, input data_byte, input data_valid, input body_done,
                input error_code, output ready);
endinterface

[sv/http_body_deframer_core.sv]
// http body deframer: takes a request body one byte per item on in_ch and
// returns one result item per byte on out_ch (payload byte and its valid
// flag, body done, error code).
// configuration: cfg_index 0 selects chunked framing, cfg_index 1 sets the
// content length for length mode; write only while no item is in flight.
// set body_start on the first byte of each body to clear the parser.
// the front classifies each byte (hex digit, cr, lf, extension delimiter)
// and places it in a two item queue; the back holds the parser state and
// writes one result a cycle into the output register unless out_ch stalls.
// an accepted item passes through the queue and then the output register
// before its result shows on out_ch.
// throughput: one item per cycle unless out_ch stalls; the parser updates on each item.
// reset: parser state, queue and both registers clear (length mode, length
// zero); no item is held after reset.
// when the receiver stalls the output register holds its item, the queue
// fills behind it and in_ch.ready falls once two more items wait.
module http_body_deframer_core import hbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hbd_in_if.sink                in_ch,
  hbd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  chunked_mode_r;
  logic [CFG_DATA_W-1:0] body_len_r;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  hbd_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r <= 1'b0;
      body_len_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKED_MODE: chunked_mode_r <= cfg_wdata[0];
        CFG_BODY_LEN:     body_len_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hbd_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .chunked_mode (chunked_mode_r),
    .body_len     (body_len_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_ch       (out_ch)
  );

endmodule

[sv/hbd_front.sv]
module hbd_front import hbd_pkg::*; (
  hbd_in_if.sink    in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output hbd_item_t push_item
);

  logic [7:0] b;

  assign b = in_ch.body_byte;
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_item = '0;
    push_item.body_byte  = b;
    push_item.body_start = in_ch.body_start;
    push_item.is_cr  = (b == CH_CR);
    push_item.is_lf  = (b == CH_LF);
    push_item.is_ext = (b == CH_SEMI) || (b == CH_SPACE) || (b == CH_TAB);
    if (b >= 8'h30 && b <= 8'h39) begin
      push_item.is_hex  = 1'b1;
      push_item.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      // letters a-f and A-F share the low three bits
      push_item.is_hex  = 1'b1;
      push_item.hex_val = 4'd9 + {1'b0, b[2:0]};
    end
  end

endmodule

[sv/hbd_queue.sv]
`include "assert_macros.svh"

module hbd_queue import hbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  hbd_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output hbd_item_t pop_item
);

  hbd_item_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= QCNT_W'(QUEUE_DEPTH),
                 "queue count beyond depth")
  `ASSERT_CLK(a_fill_step, push && !pop |=> count_r == $past(count_r) + 1'b1,
              "queue count missed a push")

endmodule

[sv/hbd_back.sv]
`include "assert_macros.svh"

module hbd_back import hbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  chunked_mode,
  input  logic [CFG_DATA_W-1:0] body_len,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  hbd_item_t             pop_item,
  hbd_out_if.source             out_ch
);

  // wide enough for the chunk size and for the byte count of length mode
  localparam int CNT_W = (SIZE_BITS > CFG_DATA_W) ? SIZE_BITS : CFG_DATA_W;
  // largest size that can still take one more digit
  localparam logic [CNT_W-1:0] SIZE_LIM = (CNT_W'(1) << (SIZE_BITS - 4)) - CNT_W'(1);

  typedef enum logic [2:0] {
    PH_SIZE, PH_SIZE_LF, PH_DATA, PH_SKIP1, PH_SKIP2, PH_END_CR, PH_END_LF, PH_HALT
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] remaining_r, remaining_nxt;
  logic [3:0]       hex_digits_r, hex_digits_nxt;
  logic             ext_r, ext_nxt;
  logic             finished_r, finished_nxt;
  logic [1:0]       err_latched_r, err_latched_nxt;

  logic             out_valid_r;
  logic [7:0]       data_byte_r, data_byte_nxt;
  logic             data_valid_r, data_valid_nxt;
  logic             body_done_r, body_done_nxt;
  logic [1:0]       error_code_r, error_code_nxt;

  logic             pop;
  logic [CNT_W-1:0] len_ext, rem_inc, rem_dec;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;
  assign len_ext   = CNT_W'(body_len);

  always_comb begin
    phase_nxt       = pop_item.body_start ? PH_SIZE : phase_r;
    remaining_nxt   = pop_item.body_start ? '0 : remaining_r;
    hex_digits_nxt  = pop_item.body_start ? '0 : hex_digits_r;
    ext_nxt         = pop_item.body_start ? 1'b0 : ext_r;
    finished_nxt    = pop_item.body_start ? 1'b0 : finished_r;
    err_latched_nxt = pop_item.body_start ? ERR_NONE : err_latched_r;
    rem_inc         = remaining_nxt + 1'b1;
    rem_dec         = (remaining_nxt != '0) ? remaining_nxt - 1'b1 : remaining_nxt;

    data_byte_nxt  = '0;
    data_valid_nxt = 1'b0;
    body_done_nxt  = 1'b0;
    error_code_nxt = ERR_NONE;

    if (phase_nxt == PH_HALT) begin
      error_code_nxt = err_latched_nxt;
    end else if (finished_nxt) begin
      body_done_nxt  = 1'b1;
      error_code_nxt = ERR_AFTER;
    end else if (!chunked_mode) begin
      if (remaining_nxt >= len_ext) begin
        finished_nxt   = 1'b1;
        body_done_nxt  = 1'b1;
        error_code_nxt = ERR_AFTER;
      end else begin
        data_byte_nxt  = pop_item.body_byte;
        data_valid_nxt = 1'b1;
        remaining_nxt  = rem_inc;
        if (rem_inc >= len_ext) begin
          finished_nxt  = 1'b1;
          body_done_nxt = 1'b1;
        end
      end
    end else begin
      case (phase_nxt)
        PH_SIZE: begin
          if (pop_item.is_cr) begin
            if (hex_digits_nxt == '0) begin
              phase_nxt       = PH_HALT;
              err_latched_nxt = ERR_SIZE;
              error_code_nxt  = ERR_SIZE;
            end else begin
              phase_nxt = PH_SIZE_LF;
            end
          end else if (ext_nxt) begin
            // chunk extension, ignored up to cr
          end else if (pop_item.is_hex) begin
            if (remaining_nxt > SIZE_LIM) begin
              phase_nxt       = PH_HALT;
              err_latched_nxt = ERR_SIZE;
              error_code_nxt  = ERR_SIZE;
            end else begin
              remaining_nxt = {remaining_nxt[CNT_W-5:0], pop_item.hex_val};
              if (hex_digits_nxt != 4'hf) begin
                hex_digits_nxt = hex_digits_nxt + 1'b1;
              end
            end
          end else if (hex_digits_nxt != '0 && pop_item.is_ext) begin
            ext_nxt = 1'b1;
          end else begin
            phase_nxt       = PH_HALT;
            err_latched_nxt = ERR_SIZE;
            error_code_nxt  = ERR_SIZE;
          end
        end
        PH_SIZE_LF: begin
          if (!pop_item.is_lf) begin
            phase_nxt       = PH_HALT;
            err_latched_nxt = ERR_TERM;
            error_code_nxt  = ERR_TERM;
          end else begin
            hex_digits_nxt = '0;
            ext_nxt        = 1'b0;
            phase_nxt      = (remaining_nxt == '0) ? PH_END_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          data_byte_nxt  = pop_item.body_byte;
          data_valid_nxt = 1'b1;
          remaining_nxt  = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          phase_nxt = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_nxt      = PH_SIZE;
          remaining_nxt  = '0;
          hex_digits_nxt = '0;
          ext_nxt        = 1'b0;
        end
        PH_END_CR: begin
          if (pop_item.is_cr) begin
            phase_nxt = PH_END_LF;
          end else begin
            phase_nxt       = PH_HALT;
            err_latched_nxt = ERR_TERM;
            error_code_nxt  = ERR_TERM;
          end
        end
        PH_END_LF: begin
          if (pop_item.is_lf) begin
            finished_nxt  = 1'b1;
            body_done_nxt = 1'b1;
          end else begin
            phase_nxt       = PH_HALT;
            err_latched_nxt = ERR_TERM;
            error_code_nxt  = ERR_TERM;
          end
        end
        default: begin
          error_code_nxt = err_latched_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIZE;
      remaining_r   <= '0;
      hex_digits_r  <= '0;
      ext_r         <= 1'b0;
      finished_r    <= 1'b0;
      err_latched_r <= ERR_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        phase_r       <= phase_nxt;
        remaining_r   <= remaining_nxt;
        hex_digits_r  <= hex_digits_nxt;
        ext_r         <= ext_nxt;
        finished_r    <= finished_nxt;
        err_latched_r <= err_latched_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_byte_r  <= data_byte_nxt;
      data_valid_r <= data_valid_nxt;
      body_done_r  <= body_done_nxt;
      error_code_r <= error_code_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = data_byte_r;
  assign out_ch.data_valid = data_valid_r;
  assign out_ch.body_done  = body_done_r;
  assign out_ch.error_code = error_code_r;

  `ASSERT_CLK(a_data_clean, out_valid_r && data_valid_r |-> error_code_r == ERR_NONE,
              "payload byte carries an error")
  `ASSERT_CLK(a_halt_code, phase_r == PH_HALT |-> err_latched_r == ERR_SIZE ||
              err_latched_r == ERR_TERM, "halted without a size or terminator fault")

endmodule
